/* rtl/uvs_pkg.sv */
// Shared types and constants for the UV-sphere vertex generator.
`default_nettype none
package uvs_pkg;

    localparam int NUM_LANES = 3;
    localparam int LANE_TH   = 0;
    localparam int LANE_PH   = 1;
    localparam int LANE_U    = 2;

    localparam int NUM_W   = 26;
    localparam int REM_W   = 12;
    localparam int DEN_W   = 11;
    localparam int DIV_CELLS = NUM_W;
    localparam int SIN_LAT = 8;

    localparam logic [1:0] REG_LAT    = 2'd0;
    localparam logic [1:0] REG_LON    = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598669;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172274;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } div_lane_t;

    typedef struct packed {
        logic                            valid;
        logic [7:0]                      row;
        logic [8:0]                      col;
        div_lane_t [NUM_LANES-1:0]       lane;
    } cell_data_t;

    typedef logic [NUM_LANES-1:0][DEN_W-1:0] den_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [16:0] corner_a;
        logic [16:0] corner_b;
        logic [16:0] corner_c;
        logic [16:0] corner_d;
    } side_t;

endpackage
`default_nettype wire

/* rtl/uvs_div_cell.sv */
// One restoring-division cell: produces one quotient bit per lane.
`default_nettype none
module uvs_div_cell
    import uvs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire den_t       den,
    input  wire cell_data_t din,
    output cell_data_t      dout
);

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb begin
        logic [REM_W-1:0] t;
        logic             ge;
        data_next = din;
        for (int k = 0; k < NUM_LANES; k++) begin
            t  = {din.lane[k].rem[REM_W-2:0], din.lane[k].nq[NUM_W-1]};
            ge = (t >= {1'b0, den[k]});
            data_next.lane[k].rem = ge ? (t - {1'b0, den[k]}) : t;
            data_next.lane[k].nq  = {din.lane[k].nq[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule
`default_nettype wire

/* rtl/uvs_sine.sv */
// Pipelined sine of a 16-bit phase, Q2.14 result, quarter-wave polynomial.
`default_nettype none
module uvs_sine
    import uvs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [15:0]       phase,
    output logic signed [15:0]     sine
);

    logic [14:0]        a_reg;
    logic [14:0]        a_next;
    logic               neg_reg [0:6];
    logic [30:0]        x_reg   [1:5];
    logic [30:0]        x2_reg  [1:4];
    logic [30:0]        t_reg   [2:5];
    logic [30:0]        t_next  [2:5];
    logic [30:0]        coef    [2:5];
    logic [61:0]        xx;
    logic [61:0]        xr;
    logic [31:0]        r_reg;
    logic [32:0]        rnd;
    logic [14:0]        mag;
    logic signed [15:0] sine_reg;

    assign coef[2] = SIN_C7;
    assign coef[3] = SIN_C5;
    assign coef[4] = SIN_C3;
    assign coef[5] = SIN_C1;

    always_comb begin
        logic [1:0]  q;
        logic [61:0] p;
        logic [30:0] tin;
        q = phase[15:14];
        if (q[0]) begin
            a_next = 15'd16384 - {1'b0, phase[13:0]};
        end else begin
            a_next = {1'b0, phase[13:0]};
        end
        for (int k = 2; k <= 5; k++) begin
            tin = (k == 2) ? SIN_C9 : t_reg[(k == 2) ? 2 : k - 1];
            p = {31'd0, x2_reg[k - 1]} * {31'd0, tin};
            t_next[k] = 31'({1'b0, coef[k]} - p[61:30]);
        end
    end

    assign xx  = {31'd0, {a_reg, 16'd0}} * {31'd0, {a_reg, 16'd0}};
    assign xr  = {31'd0, x_reg[5]} * {31'd0, t_reg[5]};
    assign rnd = {1'b0, r_reg} + 33'd32768;
    assign mag = (rnd[32:16] > 17'd16384) ? 15'd16384 : rnd[30:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg      <= a_next;
            neg_reg[0] <= phase[15];
            x_reg[1]   <= {a_reg, 16'd0};
            x2_reg[1]  <= xx[60:30];
            for (int k = 1; k <= 6; k++) begin
                neg_reg[k] <= neg_reg[k - 1];
            end
            for (int k = 2; k <= 5; k++) begin
                x_reg[k] <= x_reg[k - 1];
                t_reg[k] <= t_next[k];
            end
            for (int k = 2; k <= 4; k++) begin
                x2_reg[k] <= x2_reg[k - 1];
            end
            r_reg    <= xr[61:30];
            sine_reg <= neg_reg[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

/* rtl/uv_sphere_vertex_generator.sv */
// UV-sphere vertex generator top level.
// Input channel s_*: one grid cell (row, column) per beat, valid/ready.
// Result channel m_*: position, normal, texture U/V and quad corner indices,
// one beat per input beat, in order.
// Config channel cfg_*: index 0 lat_steps, 1 lon_steps, 2 sphere_radius;
// cfg_ready is always high, other indexes are ignored. Write only when idle.
// Throughput: one beat per cycle unless the receiver stalls. Pipeline, from the
// input accept edge to m_valid: the 26-cell division chain that forms the angle
// phases and texture ratios (its first cell loads on the accept edge), the phase
// register, the 8-stage sine pipeline, the normal multiply stage and the output
// register that holds the radius multiply.
// The pipeline advances whenever its last stage is empty or the output
// register is free; a stalled receiver stops it once the result is waiting
// and the stage behind it is full, and s_ready drops with it.
// Reset empties the pipeline and loads lat 16, lon 32, radius 1.0.
`default_nettype none
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_LAT = 255,
    parameter int MAX_LON = 512
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_grid_row,
    input  wire logic [8:0]         s_grid_col,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [16:0]      m_pos_x,
    output logic signed [16:0]      m_pos_y,
    output logic signed [16:0]      m_pos_z,
    output logic signed [15:0]      m_norm_x,
    output logic signed [15:0]      m_norm_y,
    output logic signed [15:0]      m_norm_z,
    output logic [15:0]             m_tex_u,
    output logic [15:0]             m_tex_v,
    output logic [16:0]             m_corner_a,
    output logic [16:0]             m_corner_b,
    output logic [16:0]             m_corner_c,
    output logic [16:0]             m_corner_d,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    function automatic logic signed [15:0] mul_nn(logic signed [15:0] a,
                                                  logic signed [15:0] b);
        logic [15:0] ma;
        logic [15:0] mb;
        logic [31:0] p;
        logic [15:0] m;
        ma = a[15] ? 16'(-a) : a;
        mb = b[15] ? 16'(-b) : b;
        p  = ma * mb + 32'd8192;
        m  = p[29:14];
        return (a[15] ^ b[15]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [16:0] mul_rn(logic [15:0] rad,
                                                  logic signed [15:0] n);
        logic [15:0] mn;
        logic [31:0] p;
        logic [16:0] m;
        mn = n[15] ? 16'(-n) : n;
        p  = rad * mn + 32'd8192;
        m  = p[30:14];
        return n[15] ? -$signed(m) : $signed(m);
    endfunction

    logic [7:0]  lat_reg;
    logic [9:0]  lon_reg;
    logic [15:0] radius_reg;
    logic [7:0]  lat_eff;
    logic [9:0]  lon_eff;
    den_t        den;

    logic        out_take;
    logic        en;

    cell_data_t  chain [0:DIV_CELLS];

    logic [15:0] th_phase_reg;
    logic [15:0] ph_phase_reg;
    side_t       side_next;
    side_t       side_reg [0:SIN_LAT];

    logic signed [15:0] sth;
    logic signed [15:0] cth;
    logic signed [15:0] sph;
    logic signed [15:0] cph;

    side_t              n_side_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;

    logic               m_valid_reg;
    side_t              o_side_reg;
    logic signed [15:0] onx_reg;
    logic signed [15:0] ony_reg;
    logic signed [15:0] onz_reg;
    logic signed [16:0] px_reg;
    logic signed [16:0] py_reg;
    logic signed [16:0] pz_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg    <= 8'd16;
            lon_reg    <= 10'd32;
            radius_reg <= 16'd256;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LAT:    lat_reg    <= cfg_data[7:0];
                REG_LON:    lon_reg    <= cfg_data[9:0];
                REG_RADIUS: radius_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (lat_reg == 8'd0) begin
            lat_eff = 8'd1;
        end else if (int'(lat_reg) > MAX_LAT) begin
            lat_eff = 8'(MAX_LAT);
        end else begin
            lat_eff = lat_reg;
        end
        if (lon_reg < 10'd2) begin
            lon_eff = 10'd2;
        end else if (int'(lon_reg) > MAX_LON) begin
            lon_eff = 10'(MAX_LON);
        end else begin
            lon_eff = lon_reg;
        end
    end

    assign den[LANE_TH] = {2'd0, lat_eff, 1'b0};
    assign den[LANE_PH] = {lon_eff, 1'b0};
    assign den[LANE_U]  = {lon_eff - 10'd1, 1'b0};

    // flow control
    assign out_take = !m_valid_reg || m_ready;
    assign en       = out_take || !n_side_reg.valid;
    assign s_ready  = en;

    // division chain
    always_comb begin
        chain[0].valid = s_valid;
        chain[0].row   = s_grid_row;
        chain[0].col   = s_grid_col;
        chain[0].lane[LANE_TH].rem = '0;
        chain[0].lane[LANE_PH].rem = '0;
        chain[0].lane[LANE_U].rem  = '0;
        chain[0].lane[LANE_TH].nq  = {2'd0, s_grid_row, 16'd0} + {18'd0, lat_eff};
        chain[0].lane[LANE_PH].nq  = {s_grid_col, 17'd0} + {16'd0, lon_eff};
        chain[0].lane[LANE_U].nq   = {1'b0, s_grid_col, 16'd0}
                                   + {16'd0, lon_eff - 10'd1};
    end

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
        uvs_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .den     (den),
            .din     (chain[i]),
            .dout    (chain[i + 1])
        );
    end

    // phases, texture, corners
    always_comb begin
        logic [NUM_W-1:0] thq;
        logic [NUM_W-1:0] uq;
        logic [17:0]      base;
        logic [9:0]       nxt;
        logic [18:0]      sa;
        logic [18:0]      sb;
        logic [18:0]      sc;
        logic [18:0]      sd;
        thq  = chain[DIV_CELLS].lane[LANE_TH].nq;
        uq   = chain[DIV_CELLS].lane[LANE_U].nq;
        base = chain[DIV_CELLS].row * lon_eff;
        nxt  = ({1'b0, chain[DIV_CELLS].col} + 10'd1 < lon_eff)
             ? {1'b0, chain[DIV_CELLS].col} + 10'd1 : 10'd0;
        sa = {1'b0, base} + {10'd0, chain[DIV_CELLS].col};
        sb = {1'b0, base} + {9'd0, nxt};
        sc = {1'b0, base} + {9'd0, lon_eff} + {9'd0, nxt};
        sd = {1'b0, base} + {9'd0, lon_eff} + {10'd0, chain[DIV_CELLS].col};
        side_next.valid = chain[DIV_CELLS].valid;
        side_next.tex_v = (thq >= 26'd32768) ? 16'd0 : 16'd32768 - thq[15:0];
        side_next.tex_u = (uq >= 26'd32768) ? 16'd0 : 16'd32768 - uq[15:0];
        if (chain[DIV_CELLS].row < lat_eff) begin
            side_next.corner_a = sa[16:0];
            side_next.corner_b = sb[16:0];
            side_next.corner_c = sc[16:0];
            side_next.corner_d = sd[16:0];
        end else begin
            side_next.corner_a = '0;
            side_next.corner_b = '0;
            side_next.corner_c = '0;
            side_next.corner_d = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SIN_LAT; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= SIN_LAT; k++) begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            th_phase_reg <= chain[DIV_CELLS].lane[LANE_TH].nq[15:0] + 16'h8000;
            ph_phase_reg <= chain[DIV_CELLS].lane[LANE_PH].nq[15:0];
        end
    end

    // trig
    uvs_sine u_sth (.aclk(aclk), .en(en), .phase(th_phase_reg), .sine(sth));
    uvs_sine u_cth (.aclk(aclk), .en(en), .phase(th_phase_reg + 16'h4000), .sine(cth));
    uvs_sine u_sph (.aclk(aclk), .en(en), .phase(ph_phase_reg), .sine(sph));
    uvs_sine u_cph (.aclk(aclk), .en(en), .phase(ph_phase_reg + 16'h4000), .sine(cph));

    // normals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_side_reg <= '0;
        end else if (en) begin
            n_side_reg <= side_reg[SIN_LAT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= mul_nn(sth, cph);
            ny_reg <= cth;
            nz_reg <= mul_nn(sth, sph);
        end
    end

    // output register with position multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= n_side_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            o_side_reg <= n_side_reg;
            onx_reg    <= nx_reg;
            ony_reg    <= ny_reg;
            onz_reg    <= nz_reg;
            px_reg     <= mul_rn(radius_reg, nx_reg);
            py_reg     <= mul_rn(radius_reg, ny_reg);
            pz_reg     <= mul_rn(radius_reg, nz_reg);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pos_x    = px_reg;
    assign m_pos_y    = py_reg;
    assign m_pos_z    = pz_reg;
    assign m_norm_x   = onx_reg;
    assign m_norm_y   = ony_reg;
    assign m_norm_z   = onz_reg;
    assign m_tex_u    = o_side_reg.tex_u;
    assign m_tex_v    = o_side_reg.tex_v;
    assign m_corner_a = o_side_reg.corner_a;
    assign m_corner_b = o_side_reg.corner_b;
    assign m_corner_c = o_side_reg.corner_c;
    assign m_corner_d = o_side_reg.corner_d;

endmodule
`default_nettype wire

/* sim/uv_sphere_vertex_generator_tb.sv */
// Self-checking testbench for the UV-sphere vertex generator: directed and random grid cells.
`default_nettype none
module uv_sphere_vertex_generator_tb
    import uvs_pkg::*;
;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [16:0]        corner_a;
        logic [16:0]        corner_b;
        logic [16:0]        corner_c;
        logic [16:0]        corner_d;
    } vertex_t;

    class vertex_scoreboard;
        vertex_t pending[$];
        longint  lat_cfg = 16, lon_cfg = 32, radius_cfg = 256;
        int      errors = 0, checked = 0;

        function longint quarter_sin(longint a);
            longint x, x2, t, r;
            x  = a << 16;
            x2 = (x * x) >>> 30;
            t  = 172274;
            t  = 5026995 - ((x2 * t) >>> 30);
            t  = 85569306 - ((x2 * t) >>> 30);
            t  = 693598669 - ((x2 * t) >>> 30);
            t  = 1686629713 - ((x2 * t) >>> 30);
            r  = (x * t) >>> 30;
            r  = (r + 32768) >>> 16;
            if (r > 16384) r = 16384;
            return r;
        endfunction

        function longint phase_sin(longint p);
            longint q, r, s;
            q = (p >> 14) & 3;
            r = p & 16'h3fff;
            s = (q == 0 || q == 2) ? quarter_sin(r) : quarter_sin(16384 - r);
            return (q >= 2) ? -s : s;
        endfunction

        function longint mul14(longint a, longint b);
            longint ma, mb, m;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            m  = (ma * mb + 8192) >> 14;
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function void note_cell(logic [7:0] row_in, logic [8:0] col_in);
            longint row, col, lat, lon, thf, thp, php, sth, cth, sph, cph;
            longint nx, ny, nz, uq, nxt;
            vertex_t v;
            row = longint'(row_in);
            col = longint'(col_in);
            lat = lat_cfg < 1 ? 1 : (lat_cfg > 255 ? 255 : lat_cfg);
            lon = lon_cfg < 2 ? 2 : (lon_cfg > 512 ? 512 : lon_cfg);
            thf = (row * 65536 + lat) / (2 * lat);
            thp = (thf + 32768) & 16'hffff;
            php = ((col * 131072 + lon) / (2 * lon)) & 16'hffff;
            sth = phase_sin(thp);
            cth = phase_sin((thp + 16384) & 16'hffff);
            sph = phase_sin(php);
            cph = phase_sin((php + 16384) & 16'hffff);
            nx = mul14(sth, cph);
            ny = cth;
            nz = mul14(sth, sph);
            v.pos_x  = 17'(mul14(radius_cfg, nx));
            v.pos_y  = 17'(mul14(radius_cfg, ny));
            v.pos_z  = 17'(mul14(radius_cfg, nz));
            v.norm_x = 16'(nx);
            v.norm_y = 16'(ny);
            v.norm_z = 16'(nz);
            uq = (col * 65536 + (lon - 1)) / (2 * (lon - 1));
            v.tex_u = 16'(uq >= 32768 ? 0 : 32768 - uq);
            v.tex_v = 16'(thf >= 32768 ? 0 : 32768 - thf);
            if (row < lat) begin
                nxt = (col + 1 < lon) ? col + 1 : 0;
                v.corner_a = 17'(row * lon + col);
                v.corner_b = 17'(row * lon + nxt);
                v.corner_c = 17'((row + 1) * lon + nxt);
                v.corner_d = 17'((row + 1) * lon + col);
            end else begin
                v.corner_a = 0;
                v.corner_b = 0;
                v.corner_c = 0;
                v.corner_d = 0;
            end
            pending.insert(pending.size(), v);
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t exp_v;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
                return;
            end
            exp_v = pending.pop_front();
            checked++;
            if (exp_v.pos_x != got.pos_x)
                $display("%0t: pos_x exp %0d got %0d", $time, exp_v.pos_x, got.pos_x);
            if (exp_v.pos_y != got.pos_y)
                $display("%0t: pos_y exp %0d got %0d", $time, exp_v.pos_y, got.pos_y);
            if (exp_v.pos_z != got.pos_z)
                $display("%0t: pos_z exp %0d got %0d", $time, exp_v.pos_z, got.pos_z);
            if (exp_v.norm_x != got.norm_x)
                $display("%0t: norm_x exp %0d got %0d", $time, exp_v.norm_x, got.norm_x);
            if (exp_v.norm_y != got.norm_y)
                $display("%0t: norm_y exp %0d got %0d", $time, exp_v.norm_y, got.norm_y);
            if (exp_v.norm_z != got.norm_z)
                $display("%0t: norm_z exp %0d got %0d", $time, exp_v.norm_z, got.norm_z);
            if (exp_v.tex_u != got.tex_u)
                $display("%0t: tex_u exp %0d got %0d", $time, exp_v.tex_u, got.tex_u);
            if (exp_v.tex_v != got.tex_v)
                $display("%0t: tex_v exp %0d got %0d", $time, exp_v.tex_v, got.tex_v);
            if (exp_v.corner_a != got.corner_a)
                $display("%0t: corner_a exp %0d got %0d", $time, exp_v.corner_a, got.corner_a);
            if (exp_v.corner_b != got.corner_b)
                $display("%0t: corner_b exp %0d got %0d", $time, exp_v.corner_b, got.corner_b);
            if (exp_v.corner_c != got.corner_c)
                $display("%0t: corner_c exp %0d got %0d", $time, exp_v.corner_c, got.corner_c);
            if (exp_v.corner_d != got.corner_d)
                $display("%0t: corner_d exp %0d got %0d", $time, exp_v.corner_d, got.corner_d);
            if (exp_v != got) errors++;
        endfunction
    endclass

    localparam logic [1:0] REG_INDEX_UNUSED_GUARD = 2'd3;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_grid_row = 0;
    logic [8:0]  s_grid_col = 0;
    logic        m_valid;
    logic        m_ready = 0;
    wire vertex_t m_beat;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_LAT;
    logic [15:0] cfg_data = 0;

    vertex_scoreboard sb = new();
    bit          quiet = 0;
    int          sent = 0, idle_cycles = 0;
    bit          timed_out = 0;

    always #1 aclk = ~aclk;

    uv_sphere_vertex_generator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_grid_row(s_grid_row), .s_grid_col(s_grid_col),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_beat.pos_x), .m_pos_y(m_beat.pos_y), .m_pos_z(m_beat.pos_z),
        .m_norm_x(m_beat.norm_x), .m_norm_y(m_beat.norm_y), .m_norm_z(m_beat.norm_z),
        .m_tex_u(m_beat.tex_u), .m_tex_v(m_beat.tex_v),
        .m_corner_a(m_beat.corner_a), .m_corner_b(m_beat.corner_b),
        .m_corner_c(m_beat.corner_c), .m_corner_d(m_beat.corner_d),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_vertex(m_beat);
        if (aresetn && s_valid && s_ready) sb.note_cell(s_grid_row, s_grid_col);
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) timed_out <= 1;
    end

    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 29);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_LAT) sb.lat_cfg = longint'(val[7:0]);
        else if (idx == REG_LON) sb.lon_cfg = longint'(val[9:0]);
        else if (idx == REG_RADIUS) sb.radius_cfg = longint'(val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_cell(logic [7:0] row, logic [8:0] col);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 29) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid    <= 1;
        s_grid_row <= row;
        s_grid_col <= col;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.pending.size() != 0 && !timed_out) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic random_cells(int n, int lat, int lon);
        int r, c;
        for (int i = 0; i < n; i++) begin
            r = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(lat);
            c = ($urandom_range(9) == 0) ? $urandom_range(511) :
                $urandom_range(lon > 512 ? 511 : lon - 1);
            send_cell(8'(r), 9'(c));
        end
    endtask

    initial begin
        int lat, lon;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // reset settings: poles, seam, out-of-grid cells
        send_cell(0, 0);
        send_cell(16, 31);
        send_cell(8, 16);
        send_cell(17, 5);
        send_cell(255, 511);
        send_cell(0, 32);
        send_cell(8'haa, 9'h155);
        send_cell(8'h55, 9'h0aa);
        drain();
        write_reg(REG_LAT, 16'd0);
        write_reg(REG_LON, 16'd0);
        write_reg(REG_RADIUS, 16'hffff);
        send_cell(0, 0);
        send_cell(1, 1);
        send_cell(2, 3);
        send_cell(0, 1);
        drain();
        write_reg(REG_LAT, 16'd255);
        write_reg(REG_LON, 16'h3ff);
        write_reg(REG_RADIUS, 16'd0);
        send_cell(255, 511);
        send_cell(254, 511);
        send_cell(128, 256);
        send_cell(0, 511);
        drain();
        write_reg(REG_LON, 16'd512);
        write_reg(REG_RADIUS, 16'h8000);
        write_reg(REG_INDEX_UNUSED_GUARD, 16'h1234);
        send_cell(254, 511);
        send_cell(254, 0);
        send_cell(127, 128);
        drain();
        for (int ph = 0; ph < 10 && !timed_out; ph++) begin
            lat = (ph == 0) ? 1 : (ph == 1) ? 255 : $urandom_range(1, 255);
            lon = (ph == 0) ? 2 : (ph == 1) ? 512 : $urandom_range(2, 512);
            write_reg(REG_LAT, 16'(lat));
            write_reg(REG_LON, 16'(lon));
            write_reg(REG_RADIUS, (ph == 2) ? 16'hffff : 16'($urandom_range(65535)));
            quiet = (ph == 4);
            random_cells(133, lat, lon);
            drain();
        end
        quiet = 0;
        drain();
        $display("Covered %0d cells over 14 register settings, %0d results checked.",
                 sent, sb.checked);
        if (!timed_out && sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("Watchdog: no beat moved for too long.");
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
